@@ rtl/core/lpng_pkg.sv @@
// Package for the Lehmer pixel noise generator: constants, state encodings
// and the request/response structs between the sequencer and the draw unit.
// Depends on nothing.
`timescale 1ns / 1ps

package lpng_pkg;

  localparam logic [14:0] LCG_MULT  = 15'd16807;
  localparam logic [30:0] LCG_MOD   = 31'h7fffffff;
  localparam logic [7:0]  OPAQUE    = 8'hff;
  localparam int          DIV_STEPS = 31;
  localparam int          CNT_W     = $clog2(DIV_STEPS);
  localparam int          PROD_W    = 47;

  localparam logic [2:0] REG_SEED  = 3'd0;
  localparam logic [2:0] REG_LOW   = 3'd1;
  localparam logic [2:0] REG_HIGH  = 3'd2;
  localparam logic [2:0] REG_MASK  = 3'd3;
  localparam logic [2:0] REG_GRAY  = 3'd4;

  typedef enum logic [2:0] {
    D_IDLE,
    D_MUL,
    D_FOLD,
    D_DIV,
    D_DONE
  } draw_state_t;

  typedef enum logic [1:0] {
    P_IDLE,
    P_SEL,
    P_WAIT,
    P_FINISH
  } px_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] state;
    logic [7:0]  low;
    logic [8:0]  modulus;
  } draw_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] state;
    logic [7:0]  value;
  } draw_rsp_t;

endpackage

@@ rtl/core/lpng_draw_unit.sv @@
// One draw of the noise generator: advance the Lehmer state and reduce it
// by the channel range with a restoring serial modulo, one bit per cycle.
// Depends on lpng_pkg.
`timescale 1ns / 1ps

module lpng_draw_unit
  import lpng_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  draw_req_t req,
  output draw_rsp_t rsp
);

  draw_state_t       st_r, st_nxt;
  logic [31:0]       state_r, state_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [7:0]        low_r, low_nxt;
  logic [8:0]        mod_r, mod_nxt;
  logic [8:0]        rem_r, rem_nxt;
  logic [30:0]       quot_r, quot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [31:0] fold_sum;
  logic [31:0] fold_res;
  logic [9:0]  trial;
  logic        last_step;

  assign last_step = (cnt_r == CNT_W'(DIV_STEPS - 1));

  // Mersenne fold: 2^31 is 1 modulo 2^31-1, so the high part adds to the low.
  assign fold_sum = {16'd0, prod_r[PROD_W-1:31]} + {1'b0, prod_r[30:0]};
  assign fold_res = (fold_sum >= {1'b0, LCG_MOD}) ? (fold_sum - {1'b0, LCG_MOD}) : fold_sum;

  assign trial = {rem_r, quot_r[30]};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      D_IDLE: begin
        if (req.start) st_nxt = D_MUL;
      end
      D_MUL:  st_nxt = D_FOLD;
      D_FOLD: st_nxt = D_DIV;
      D_DIV: begin
        if (last_step) st_nxt = D_DONE;
      end
      D_DONE: st_nxt = D_IDLE;
      default: st_nxt = D_IDLE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    low_nxt   = low_r;
    mod_nxt   = mod_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    cnt_nxt   = cnt_r;
    case (st_r)
      D_IDLE: begin
        if (req.start) begin
          state_nxt = req.state;
          low_nxt   = req.low;
          mod_nxt   = req.modulus;
        end
      end
      D_MUL: begin
        prod_nxt = PROD_W'(state_r) * PROD_W'(LCG_MULT);
      end
      D_FOLD: begin
        state_nxt = fold_res;
        quot_nxt  = fold_res[30:0];
        rem_nxt   = 9'd0;
        cnt_nxt   = '0;
      end
      D_DIV: begin
        if (trial >= {1'b0, mod_r}) begin
          rem_nxt = 9'(trial - {1'b0, mod_r});
        end else begin
          rem_nxt = trial[8:0];
        end
        quot_nxt = {quot_r[29:0], 1'b0};
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    state_r <= state_nxt;
    prod_r  <= prod_nxt;
    low_r   <= low_nxt;
    mod_r   <= mod_nxt;
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_comb begin
    rsp.done  = (st_r == D_DONE);
    rsp.state = state_r;
    rsp.value = rem_r[7:0] + low_r;
  end

  a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == D_DIV || st_r == D_DONE) |-> (rem_r < mod_r))
    else $error("partial remainder not below modulus");

  a_state_folded: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == D_DONE) |-> (state_r < {1'b0, LCG_MOD}))
    else $error("advanced state not reduced below the modulus");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == D_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)))
    else $error("modulo step count ran past the last step");

endmodule

@@ rtl/core/lehmer_pixel_noise_generator.sv @@
// Top level of the Lehmer pixel noise generator: configuration registers,
// the per-pixel draw sequencer and the output register.
// Depends on lpng_pkg and lpng_draw_unit.
`timescale 1ns / 1ps

// Each accepted item produces one ARGB noise pixel from a MINSTD Lehmer
// generator (state times 16807 modulo 2^31-1). An item with in_restart set
// first reloads the generator from the seed register. Every randomized
// channel takes one draw from the shared draw unit, in the order red, green,
// blue, alpha; in gray mode one draw feeds red, green and blue, and alpha is
// a second draw when mask bit 3 is set. Channels that are not drawn read 0,
// and alpha reads 255. A draw passes through the sequencer's select state,
// then the draw unit's multiply and fold steps, its 31-step serial modulo
// and its done state. in_ready is high only while the sequencer is idle.
// The finished pixel sits in an output register, so the next item is
// accepted while the previous pixel still waits for out_ready.
// Configuration writes are always accepted; writes to indexes above four
// are ignored. out_seed_now is the generator state after this pixel's
// draws.
module lehmer_pixel_noise_generator
  import lpng_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [31:0] out_seed_now
);

  px_state_t   state_r, state_nxt;

  // Configuration registers.
  logic [31:0] seed_r;
  logic [7:0]  low_r;
  logic [7:0]  high_r;
  logic [3:0]  mask_r;
  logic        gray_r;

  logic [31:0] gen_state_r;
  logic [3:0]  pend_r;
  logic        gray_item_r;
  logic [7:0]  red_r, green_r, blue_r, alpha_r;

  logic        out_valid_r;
  logic [7:0]  out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic [31:0] out_seed_r;

  logic        in_fire;
  logic        cfg_fire;
  logic        start_draw;
  logic        take_draw;
  logic        load_out;
  logic        out_room;
  logic [3:0]  slot;
  logic [7:0]  high_eff;
  logic [8:0]  modulus;

  draw_req_t   req;
  draw_rsp_t   rsp;

  assign in_fire  = in_valid && in_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign out_room = !out_valid_r || out_ready;

  // Lowest pending channel goes next, which gives red, green, blue, alpha.
  assign slot = pend_r & (~pend_r + 4'd1);

  // A high bound below the low bound collapses the range to one value.
  assign high_eff = (high_r < low_r) ? low_r : high_r;
  assign modulus  = {1'b0, high_eff} - {1'b0, low_r} + 9'd1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      P_IDLE: begin
        if (in_valid) state_nxt = P_SEL;
      end
      P_SEL: begin
        if (pend_r == 4'd0) begin
          state_nxt = P_FINISH;
        end else begin
          state_nxt = P_WAIT;
        end
      end
      P_WAIT: begin
        if (rsp.done) state_nxt = P_SEL;
      end
      P_FINISH: begin
        if (out_room) state_nxt = P_IDLE;
      end
      default: state_nxt = P_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    start_draw = 1'b0;
    take_draw  = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      P_IDLE:   in_ready   = 1'b1;
      P_SEL:    start_draw = (pend_r != 4'd0);
      P_WAIT:   take_draw  = rsp.done;
      P_FINISH: load_out   = out_room;
      default: begin
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    req.start   = start_draw;
    req.state   = gen_state_r;
    req.low     = low_r;
    req.modulus = modulus;
  end

  lpng_draw_unit u_draw (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= P_IDLE;
      seed_r      <= 32'd0;
      low_r       <= 8'd0;
      high_r      <= 8'hff;
      mask_r      <= 4'd7;
      gray_r      <= 1'b0;
      gen_state_r <= 32'd0;
      pend_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_fire) begin
        case (cfg_index)
          REG_SEED: seed_r <= cfg_data;
          REG_LOW:  low_r  <= cfg_data[7:0];
          REG_HIGH: high_r <= cfg_data[7:0];
          REG_MASK: mask_r <= cfg_data[3:0];
          REG_GRAY: gray_r <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (in_fire) begin
        if (in_restart) gen_state_r <= seed_r;
        // Gray mode draws once for the color slot and maybe once for alpha.
        pend_r <= gray_r ? {mask_r[3], 3'b001} : mask_r;
      end else if (take_draw) begin
        gen_state_r <= rsp.state;
        pend_r      <= pend_r & ~slot;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      gray_item_r <= gray_r;
      red_r       <= 8'd0;
      green_r     <= 8'd0;
      blue_r      <= 8'd0;
      alpha_r     <= OPAQUE;
    end else if (take_draw) begin
      if (slot[0]) begin
        red_r <= rsp.value;
        if (gray_item_r) begin
          green_r <= rsp.value;
          blue_r  <= rsp.value;
        end
      end
      if (slot[1]) green_r <= rsp.value;
      if (slot[2]) blue_r  <= rsp.value;
      if (slot[3]) alpha_r <= rsp.value;
    end

    if (load_out) begin
      out_red_r   <= red_r;
      out_green_r <= green_r;
      out_blue_r  <= blue_r;
      out_alpha_r <= alpha_r;
      out_seed_r  <= gen_state_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_red      = out_red_r;
  assign out_green    = out_green_r;
  assign out_blue     = out_blue_r;
  assign out_alpha    = out_alpha_r;
  assign out_seed_now = out_seed_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("sequencer ready again right after taking an item");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == P_WAIT))
    else $error("draw finished while the sequencer was not waiting");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(out_red_r) && $stable(out_seed_r)))
    else $error("pending pixel overwritten before it was taken");

  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == P_FINISH && gray_item_r) |->
      (red_r == green_r && green_r == blue_r))
    else $error("gray pixel has unequal color channels");

endmodule

@@ bench/lehmer_pixel_noise_checker.sv @@
// Checker for the Lehmer pixel noise generator: watches the configuration,
// input and pixel channels, predicts every pixel and compares it field by field.
// Depends on lpng_pkg.
`timescale 1ns / 1ps

module lehmer_pixel_noise_checker
  import lpng_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_restart,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_alpha,
  input  logic [31:0] out_seed_now,
  output int          mismatch_count,
  output int          pixels_pending
);

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] seed_now;
  } pixel_t;

  logic [31:0] seed_reg;
  logic [7:0]  low_reg;
  logic [7:0]  high_reg;
  logic [3:0]  mask_reg;
  logic        gray_reg;
  logic [31:0] gen_state;
  pixel_t      expected_pixels[$];
  pixel_t      want;

  function automatic logic [31:0] minstd_next(logic [31:0] s);
    logic [63:0] prod;
    logic [63:0] rem;
    prod = {32'd0, s} * {49'd0, LCG_MULT};
    rem  = prod % {33'd0, LCG_MOD};
    return rem[31:0];
  endfunction

  // Advances the generator once and scales the new state into the bounds.
  function automatic logic [7:0] draw_channel(logic [8:0] span, logic [7:0] lo);
    logic [31:0] rem;
    gen_state = minstd_next(gen_state);
    rem = gen_state % {23'd0, span};
    return rem[7:0] + lo;
  endfunction

  function automatic pixel_t predict_pixel(logic restart);
    pixel_t     px;
    logic [7:0] hi_eff;
    logic [8:0] span;
    if (restart) begin
      gen_state = seed_reg;
    end
    hi_eff = (high_reg < low_reg) ? low_reg : high_reg;
    span = {1'b0, hi_eff} - {1'b0, low_reg} + 9'd1;
    px.red = 8'd0;
    px.green = 8'd0;
    px.blue = 8'd0;
    px.alpha = OPAQUE;
    if (gray_reg) begin
      px.red = draw_channel(span, low_reg);
      px.green = px.red;
      px.blue = px.red;
    end else begin
      if (mask_reg[0]) px.red = draw_channel(span, low_reg);
      if (mask_reg[1]) px.green = draw_channel(span, low_reg);
      if (mask_reg[2]) px.blue = draw_channel(span, low_reg);
    end
    if (mask_reg[3]) px.alpha = draw_channel(span, low_reg);
    px.seed_now = gen_state;
    return px;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("%0t ns: pixel mismatch on %s: got %0h, expected %0h",
             $time, what, got, exp_val);
    mismatch_count = mismatch_count + 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_reg = 32'd0;
      low_reg = 8'd0;
      high_reg = 8'd255;
      mask_reg = 4'd7;
      gray_reg = 1'b0;
      gen_state = 32'd0;
      expected_pixels.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected pixel, seed_now", out_seed_now, 32'd0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_red !== want.red) begin
            report_mismatch("red", 32'(out_red), 32'(want.red));
          end
          if (out_green !== want.green) begin
            report_mismatch("green", 32'(out_green), 32'(want.green));
          end
          if (out_blue !== want.blue) begin
            report_mismatch("blue", 32'(out_blue), 32'(want.blue));
          end
          if (out_alpha !== want.alpha) begin
            report_mismatch("alpha", 32'(out_alpha), 32'(want.alpha));
          end
          if (out_seed_now !== want.seed_now) begin
            report_mismatch("seed_now", out_seed_now, want.seed_now);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SEED: seed_reg = cfg_data;
          REG_LOW:  low_reg = cfg_data[7:0];
          REG_HIGH: high_reg = cfg_data[7:0];
          REG_MASK: mask_reg = cfg_data[3:0];
          REG_GRAY: gray_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_pixels.insert(expected_pixels.size(), predict_pixel(in_restart));
      end
    end
    pixels_pending <= expected_pixels.size();
  end

endmodule

@@ bench/lehmer_pixel_noise_generator_tb.sv @@
// Testbench top for the Lehmer pixel noise generator: clock, reset, stimulus,
// receiver back-pressure and the final verdict.
// Depends on lpng_pkg, lehmer_pixel_noise_generator and lehmer_pixel_noise_checker.
`timescale 1ns / 1ps

module lehmer_pixel_noise_generator_tb
  import lpng_pkg::*;
();

  // Length of the long receiver hold-off. Long enough for several four-draw
  // pixels, so the output register and the sequencer both fill up.
  localparam int HOLD_CYCLES = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_SEED;
  logic [31:0] cfg_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [31:0] out_seed_now;

  int mismatch_count;
  int pixels_pending;

  // Percentages for the current phase: how often the sender leaves a cycle
  // empty and how often the receiver drops out_ready.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // The stimulus flips hold_toggle to ask the receiver for a long hold-off;
  // the receiver counts the stretch down in its own process.
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lehmer_pixel_noise_generator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha),
    .out_seed_now (out_seed_now)
  );

  lehmer_pixel_noise_checker pixel_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_seed_now   (out_seed_now),
    .mismatch_count (mismatch_count),
    .pixels_pending (pixels_pending)
  );

  // Receiver. Outside a hold-off, out_ready is drawn fresh every cycle, so
  // stalls land on every phase of the pixel sequencer's work.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one item and returns at the edge where it is accepted. in_valid is
  // left high, so a following call keeps the channel busy without a bubble;
  // an idle gap lowers it first.
  task automatic send_pixel(logic restart);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering items and waits until every predicted pixel has come out.
  // The first edge lets the pending count catch up with the last item.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
  endtask

  task automatic wait_cfg();
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all five registers while the block is idle. Unused upper data bits
  // carry random noise, which the block must drop. With junk set, a write to
  // an index above the last register follows, which must change nothing.
  task automatic load_config(logic [31:0] seed, logic [7:0] lo, logic [7:0] hi,
                             logic [3:0] mask, logic gray, logic junk);
    logic [31:0] noise;
    noise = $urandom;
    quiesce();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SEED;
    cfg_data <= seed;
    wait_cfg();
    cfg_index <= REG_LOW;
    cfg_data <= {noise[31:8], lo};
    wait_cfg();
    cfg_index <= REG_HIGH;
    cfg_data <= {noise[23:0], hi};
    wait_cfg();
    cfg_index <= REG_MASK;
    cfg_data <= {noise[27:0], mask};
    wait_cfg();
    cfg_index <= REG_GRAY;
    cfg_data <= {noise[31:1], gray};
    wait_cfg();
    if (junk) begin
      cfg_index <= REG_GRAY + 3'($urandom_range(3, 1));
      cfg_data <= $urandom;
      wait_cfg();
    end
    cfg_valid <= 1'b0;
  endtask

  // Bounds lean toward the ends of the byte range.
  function automatic logic [7:0] edgy_byte();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] seed_pick;
    logic [7:0]  lo_pick;
    logic [7:0]  hi_pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling on either side.
    // Reset state is zero, so the first pixels come from a stuck generator,
    // with and without a restart from the zero seed.
    send_pixel(1'b0);
    send_pixel(1'b1);

    // Seed one gives the textbook MINSTD sequence.
    load_config(32'd1, 8'd0, 8'd255, 4'd7, 1'b0, 1'b0);
    send_pixel(1'b1);
    send_pixel(1'b0);
    send_pixel(1'b0);

    // A seed equal to the modulus collapses to zero, so every draw is low.
    load_config({1'b0, LCG_MOD}, 8'd5, 8'd9, 4'd15, 1'b0, 1'b1);
    send_pixel(1'b1);
    send_pixel(1'b0);

    // Largest seed, and a high bound below the low bound: all draws are low.
    load_config(32'hffff_ffff, 8'd200, 8'd10, 4'd15, 1'b0, 1'b0);
    send_pixel(1'b1);
    send_pixel(1'b0);

    // Seed above the modulus, a one-value range, only alpha drawn.
    load_config(32'h8000_0000, 8'd0, 8'd0, 4'd8, 1'b0, 1'b0);
    send_pixel(1'b1);
    send_pixel(1'b0);

    // No channel drawn: the generator must not move.
    load_config(32'd12345, 8'd255, 8'd255, 4'd0, 1'b0, 1'b0);
    send_pixel(1'b1);
    send_pixel(1'b0);

    // Gray mode with alpha drawn.
    load_config(32'd42, 8'd16, 8'd47, 4'd8, 1'b1, 1'b0);
    send_pixel(1'b1);
    send_pixel(1'b0);

    // Gray mode ignores the color mask bits; alpha stays opaque.
    load_config(32'd7, 8'd0, 8'd255, 4'd7, 1'b1, 1'b1);
    send_pixel(1'b1);
    send_pixel(1'b0);

    // Gray mode with an empty mask still draws the gray value.
    load_config(32'd99, 8'd100, 8'd100, 4'd0, 1'b1, 1'b0);
    send_pixel(1'b1);

    // Largest seed below the modulus, all four channels.
    load_config(32'h7fff_fffe, 8'd0, 8'd255, 4'd15, 1'b0, 1'b0);
    send_pixel(1'b1);
    send_pixel(1'b0);

    // Random part: sixteen phases, each with its own settings, cycling
    // through the idling modes.
    for (int phase = 0; phase < 16; phase++) begin
      case ($urandom_range(5))
        0: seed_pick = 32'd0;
        1: seed_pick = {1'b0, LCG_MOD};
        2: seed_pick = 32'hffff_ffff;
        3: seed_pick = 32'd1;
        default: seed_pick = $urandom;
      endcase
      lo_pick = edgy_byte();
      hi_pick = edgy_byte();
      load_config(seed_pick, lo_pick, hi_pick, 4'($urandom_range(15)),
                  ($urandom_range(3) == 0), ($urandom_range(3) == 0));

      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 57;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 57;
        end
        default: begin
          send_idle_pct = 12;
          recv_stall_pct <= 12;
        end
      endcase

      // In two of the no-idling phases the receiver goes quiet for a long
      // stretch while the sender keeps offering items, so the block backs up
      // and holds in_ready low.
      if (phase == 4 || phase == 12) begin
        hold_toggle <= ~hold_toggle;
      end

      for (int n = 0; n < 118; n++) begin
        // Some phases stop halfway and let the block drain completely.
        if (n == 59 && phase % 3 == 1) begin
          quiesce();
        end
        if (n == 0) begin
          send_pixel($urandom_range(3) != 0);
        end else begin
          send_pixel($urandom_range(15) == 0);
        end
      end
    end

    // Drain, then give a stray pixel time to show up before the verdict.
    quiesce();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pixels_pending == 0) begin
      $display("lehmer_pixel_noise_generator_tb: PASS");
    end else begin
      $display("lehmer_pixel_noise_generator_tb: FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #20_000_000;
    $display("lehmer_pixel_noise_generator_tb: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/lpng_pkg.sv
rtl/core/lpng_draw_unit.sv
rtl/core/lehmer_pixel_noise_generator.sv
bench/lehmer_pixel_noise_checker.sv
bench/lehmer_pixel_noise_generator_tb.sv
